// File: design/ocftc_pkg.sv
`timescale 1ns / 1ps

package ocftc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int POS_W     = 12;
    localparam int PHASE_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 2'd2;

    localparam logic [1:0] REG_SIDE_A   = 2'd0;
    localparam logic [1:0] REG_FADE_OUT = 2'd1;
    localparam logic [1:0] REG_FADE_IN  = 2'd2;
    localparam logic [1:0] REG_SIDE_B   = 2'd3;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] W_ONE   = 64'd32768;

    // sin^2 of angle y (Q30), Taylor series to x^13, result in unsigned Q1.15
    function automatic logic [15:0] window_from_angle(input logic [63:0] y);
        logic [63:0]        y2;
        logic [63:0]        t;
        logic signed [63:0] acc;
        logic [63:0]        s;
        logic [63:0]        v;
        y2  = (y * y) >> 30;
        t   = y;
        acc = $signed(y);
        t   = ((t * y2) >> 30) / 6;
        acc = acc - $signed(t);
        t   = ((t * y2) >> 30) / 20;
        acc = acc + $signed(t);
        t   = ((t * y2) >> 30) / 42;
        acc = acc - $signed(t);
        t   = ((t * y2) >> 30) / 72;
        acc = acc + $signed(t);
        t   = ((t * y2) >> 30) / 110;
        acc = acc - $signed(t);
        t   = ((t * y2) >> 30) / 156;
        acc = acc + $signed(t);
        if (acc < 0) begin
            s = 64'd0;
        end else if ($unsigned(acc) > ONE_Q30) begin
            s = ONE_Q30;
        end else begin
            s = $unsigned(acc);
        end
        v = (s * s + (64'd1 << 44)) >> 45;
        if (v > W_ONE) begin
            v = W_ONE;
        end
        return v[15:0];
    endfunction

endpackage

// File: design/ocftc_in_if.sv
`timescale 1ns / 1ps

interface ocftc_in_if import ocftc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

// File: design/ocftc_out_if.sv
`timescale 1ns / 1ps

interface ocftc_out_if import ocftc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       block_done;

    modport source (output valid, output out_sample, output block_done, input ready);
    modport sink   (input valid, input out_sample, input block_done, output ready);
endinterface

// File: design/overlap_crossfade_time_compressor.sv
`timescale 1ns / 1ps

// Cross-fade time compressor for 16-bit mono audio. Each block passes side_length samples,
// stores fade_length samples under a falling raised-cosine window, adds fade_length samples
// under the rising window to the stored ones, then passes side_length samples; the fade-out
// samples give no output beat. One sample is taken every cycle while the pipeline has room;
// a result passes window ROM read, multiply and fade store read and add into the output
// register. The throughput is set by the single-write, single-read fade store, which holds
// MAX_FADE words and needs no clearing pass after reset. Four beats of buffering let input
// continue while the output is stalled. Configuration may change at any point of a block,
// but only while no sample is in flight; it applies from the next input beat.
module overlap_crossfade_time_compressor import ocftc_pkg::*; #(
    parameter int MAX_FADE         = 2048,
    parameter int WINDOW_ROM_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    ocftc_in_if.sink             i_in,
    ocftc_out_if.source          o_out
);

    localparam int AW   = $clog2(MAX_FADE);
    localparam int RW   = $clog2(WINDOW_ROM_DEPTH);
    localparam int FW   = AW + POS_W;
    localparam int IPW  = PHASE_W + RW + 1;

    typedef struct packed {
        logic [1:0]                 region;
        logic [AW-1:0]              addr;
        logic                       done;
        logic signed [SAMPLE_W-1:0] sample;
    } t_ctl;

    function automatic logic [POS_W-1:0] eff_fade(input logic [POS_W-1:0] v);
        logic [FW-1:0] ext;
        ext = FW'(v);
        if (v == '0) begin
            eff_fade = POS_W'(1);
        end else if (ext > FW'(MAX_FADE)) begin
            eff_fade = POS_W'(MAX_FADE);
        end else begin
            eff_fade = v;
        end
    endfunction

    // window table
    logic [15:0] rom_tab [WINDOW_ROM_DEPTH];

    for (genvar g = 0; g < WINDOW_ROM_DEPTH; g++) begin : g_rom
        localparam logic [63:0] ANGLE = (PI_Q30 * 64'(g)) / (64'd2 * 64'(WINDOW_ROM_DEPTH));
        localparam logic [15:0] ENTRY = window_from_angle(ANGLE);
        assign rom_tab[g] = ENTRY;
    end

    // configuration
    logic [POS_W-1:0]   r_side, n_side;
    logic [POS_W-1:0]   r_fade, n_fade;
    logic [PHASE_W-1:0] r_step, n_step;
    logic [PHASE_W-1:0] r_start, n_start;
    logic [POS_W+PHASE_W-1:0] start_prod;

    always_comb begin
        n_side = r_side;
        n_fade = r_fade;
        n_step = r_step;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIDE_LENGTH: n_side = i_cfg_data[POS_W-1:0];
                CFG_FADE_LENGTH: n_fade = i_cfg_data[POS_W-1:0];
                CFG_PHASE_STEP:  n_step = i_cfg_data[PHASE_W-1:0];
                default: ;
            endcase
        end
        start_prod = (POS_W+PHASE_W)'(eff_fade(n_fade) - POS_W'(1)) * (POS_W+PHASE_W)'(n_step);
        n_start    = start_prod[PHASE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side  <= '0;
            r_fade  <= POS_W'(1);
            r_step  <= '0;
            r_start <= '0;
        end else begin
            r_side  <= n_side;
            r_fade  <= n_fade;
            r_step  <= n_step;
            r_start <= n_start;
        end
    end

    // block sequencing
    logic [1:0]         r_region, n_region;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [PHASE_W-1:0] r_phase, n_phase;

    logic [POS_W-1:0]   fade_eff, cur_len, pos_eff;
    logic [POS_W:0]     pos_inc;
    logic [1:0]         reg_eff, reg_nxt;
    logic [PHASE_W-1:0] phase_eff;
    logic               side0;
    logic               blk_done;
    logic [FW-1:0]      pos_ext;
    logic [IPW-1:0]     idx_prod;

    always_comb begin
        fade_eff = eff_fade(r_fade);
        side0    = (r_side == '0);
        cur_len  = (r_region == REG_FADE_OUT || r_region == REG_FADE_IN) ? fade_eff : r_side;
        reg_nxt  = r_region + 2'd1;
        if (r_pos < cur_len) begin
            reg_eff   = r_region;
            pos_eff   = r_pos;
            phase_eff = r_phase;
        end else begin
            pos_eff = '0;
            if (side0 && (reg_nxt == REG_SIDE_B || reg_nxt == REG_SIDE_A)) begin
                reg_eff = REG_FADE_OUT;
            end else begin
                reg_eff = reg_nxt;
            end
            if (reg_eff == REG_FADE_OUT) begin
                phase_eff = r_start;
            end else if (reg_eff == REG_FADE_IN) begin
                phase_eff = '0;
            end else begin
                phase_eff = r_phase;
            end
        end
        pos_inc = {1'b0, pos_eff} + (POS_W+1)'(1);
        unique case (reg_eff)
            REG_FADE_OUT: begin
                blk_done = 1'b0;
                n_phase  = phase_eff - r_step;
            end
            REG_FADE_IN: begin
                blk_done = side0 && (pos_inc >= {1'b0, fade_eff});
                n_phase  = phase_eff + r_step;
            end
            REG_SIDE_B: begin
                blk_done = (pos_inc >= {1'b0, r_side});
                n_phase  = phase_eff;
            end
            default: begin
                blk_done = 1'b0;
                n_phase  = phase_eff;
            end
        endcase
        n_region = reg_eff;
        n_pos    = pos_inc[POS_W-1:0];
        pos_ext  = FW'(pos_eff);
        idx_prod = IPW'(phase_eff) * IPW'(WINDOW_ROM_DEPTH);
    end

    // pipeline
    logic              r_p1_v, r_p2_v, r_p3_v;
    t_ctl              r_p1, r_p2, r_p3;
    logic [RW-1:0]     r_p1_idx;
    logic [15:0]       r_p2_w;
    logic [SAMPLE_W-1:0] r_p3_scaled;
    logic [SAMPLE_W-1:0] r_rdata, r_fwd_data;
    logic              r_fwd;

    logic              r_o_valid;
    logic [SAMPLE_W-1:0] r_o_sample;
    logic              r_o_done;

    logic en_out, en3, en2, en1, acc, wr;
    logic signed [32:0] sc_prod, sc_bias, sc_shift;
    logic [SAMPLE_W-1:0] old_val;

    assign en_out = !r_o_valid || o_out.ready;
    assign en3    = !r_p3_v || (r_p3.region == REG_FADE_OUT) || en_out;
    assign en2    = !r_p2_v || en3;
    assign en1    = !r_p1_v || en2;
    assign acc    = i_in.valid && en1;
    assign wr     = r_p3_v && en3 && (r_p3.region == REG_FADE_OUT);

    always_comb begin
        sc_prod  = r_p2.sample * $signed({1'b0, r_p2_w});
        sc_bias  = sc_prod + (sc_prod[32] ? 33'sd32767 : 33'sd0);
        sc_shift = sc_bias >>> 15;
        old_val  = r_fwd ? r_fwd_data : r_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region  <= REG_SIDE_A;
            r_pos     <= '0;
            r_phase   <= '0;
            r_p1_v    <= 1'b0;
            r_p2_v    <= 1'b0;
            r_p3_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_region <= n_region;
                r_pos    <= n_pos;
                r_phase  <= n_phase;
            end
            if (en1) begin
                r_p1_v <= i_in.valid;
            end
            if (en2) begin
                r_p2_v <= r_p1_v;
            end
            if (en3) begin
                r_p3_v <= r_p2_v;
            end
            if (en_out) begin
                r_o_valid <= r_p3_v && (r_p3.region != REG_FADE_OUT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p1.region <= reg_eff;
            r_p1.addr   <= pos_ext[AW-1:0];
            r_p1.done   <= blk_done;
            r_p1.sample <= i_in.in_sample;
            r_p1_idx    <= idx_prod[PHASE_W +: RW];
        end
        if (en2) begin
            r_p2   <= r_p1;
            r_p2_w <= rom_tab[r_p1_idx];
        end
        if (en3) begin
            r_p3        <= r_p2;
            r_p3_scaled <= sc_shift[SAMPLE_W-1:0];
            r_fwd       <= wr && (r_p3.addr == r_p2.addr);
            r_fwd_data  <= r_p3_scaled;
        end
        if (en_out) begin
            r_o_sample <= (r_p3.region == REG_FADE_IN) ? old_val + r_p3_scaled : r_p3.sample;
            r_o_done   <= r_p3.done;
        end
    end

    // fade store, read-first
    logic [SAMPLE_W-1:0] fade_mem [MAX_FADE];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            fade_mem[r_p3.addr] <= r_p3_scaled;
        end
        if (en3) begin
            r_rdata <= fade_mem[r_p2.addr];
        end
    end

    assign i_in.ready       = en1;
    assign o_out.valid      = r_o_valid;
    assign o_out.out_sample = r_o_sample;
    assign o_out.block_done = r_o_done;

endmodule

// File: sim/ocftc_compare.sv
`timescale 1ns / 1ps

module ocftc_compare import ocftc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    ocftc_in_if                  i_in_ch,
    ocftc_out_if                 i_out_ch,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_fade_room
);

    localparam int WINDOW_DEPTH = 1024;
    localparam int STORE_DEPTH  = 2048;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int Q15_ONE      = 32768;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                done;
    } t_mix_beat;

    int unsigned         window_rom [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] fade_mem [STORE_DEPTH];
    t_mix_beat           due_beats [$];
    logic [POS_W-1:0]    side_len;
    logic [POS_W-1:0]    fade_len;
    logic [POS_W-1:0]    seg_pos;
    logic [PHASE_W-1:0]  phase_inc;
    logic [PHASE_W-1:0]  phase;
    logic [1:0]          seg;
    int                  stored_count;
    int                  errors;

    // sin^2 over a quarter turn, Q30 Taylor series, rounded to Q1.15
    function automatic int unsigned sin2_q15(input int unsigned r);
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned term;
        longint unsigned mag;
        longint unsigned v;
        longint          acc;
        int              k;
        ang  = (PI_Q30 * r) / (2 * WINDOW_DEPTH);
        ang2 = (ang * ang) >> 30;
        term = ang;
        acc  = $signed(ang);
        for (k = 1; k <= 6; k++) begin
            term = ((term * ang2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0) begin
            mag = 0;
        end else if (acc > $signed(ONE_Q30)) begin
            mag = ONE_Q30;
        end else begin
            mag = acc;
        end
        v = (mag * mag + (64'd1 << 44)) >> 45;
        if (v > Q15_ONE) begin
            v = Q15_ONE;
        end
        return 32'(v);
    endfunction

    function automatic int fade_eff(input logic [POS_W-1:0] f);
        if (f == 0) begin
            return 1;
        end
        if (f > STORE_DEPTH) begin
            return STORE_DEPTH;
        end
        return int'(f);
    endfunction

    function automatic int seg_length(input logic [1:0] s);
        return (s == REG_FADE_OUT || s == REG_FADE_IN) ? fade_eff(fade_len) : int'(side_len);
    endfunction

    function automatic logic [SAMPLE_W-1:0] windowed(input logic [SAMPLE_W-1:0] raw);
        int s;
        int w;
        int idx;
        s   = int'($signed(raw));
        idx = (int'(phase) * WINDOW_DEPTH) >> 16;
        w   = window_rom[idx];
        return SAMPLE_W'((s * w) / Q15_ONE);
    endfunction

    task automatic enter_segment(input logic [1:0] s);
        seg     = s;
        seg_pos = '0;
        if (s == REG_FADE_OUT) begin
            phase = PHASE_W'((fade_eff(fade_len) - 1) * phase_inc);
        end else if (s == REG_FADE_IN) begin
            phase = '0;
        end
    endtask

    task automatic compress_sample(input logic [SAMPLE_W-1:0] raw);
        int                  hops;
        logic [SAMPLE_W-1:0] scaled;
        t_mix_beat           beat;
        hops = 0;
        while (hops < 4 && int'(seg_pos) >= seg_length(seg)) begin
            enter_segment(seg + 2'd1);
            hops++;
        end
        scaled = windowed(raw);
        case (seg)
            REG_FADE_OUT: begin
                fade_mem[seg_pos[STORE_AW-1:0]] = scaled;
                if (int'(seg_pos) + 1 > stored_count) begin
                    stored_count = int'(seg_pos) + 1;
                end
                phase = phase - phase_inc;
            end
            REG_FADE_IN: begin
                beat.sample = fade_mem[seg_pos[STORE_AW-1:0]] + scaled;
                beat.done   = (side_len == 0) && (int'(seg_pos) + 1 >= fade_eff(fade_len));
                due_beats.push_back(beat);
                phase = phase + phase_inc;
            end
            default: begin
                beat.sample = raw;
                beat.done   = (seg == REG_SIDE_B) && (int'(seg_pos) + 1 >= int'(side_len));
                due_beats.push_back(beat);
            end
        endcase
        seg_pos = seg_pos + 1'b1;
    endtask

    task automatic check_beat(input logic [SAMPLE_W-1:0] got_sample, input logic got_done);
        t_mix_beat want;
        if (due_beats.size() == 0) begin
            $error("out_sample: expected none, actual %0d", $signed(got_sample));
            errors++;
        end else begin
            want = due_beats.pop_front();
            if (want.sample !== got_sample) begin
                $error("out_sample: expected %0d, actual %0d",
                       $signed(want.sample), $signed(got_sample));
                errors++;
            end
            if (want.done !== got_done) begin
                $error("block_done: expected %0b, actual %0b", want.done, got_done);
                errors++;
            end
        end
    endtask

    initial begin
        for (int r = 0; r < WINDOW_DEPTH; r++) begin
            window_rom[r] = sin2_q15(r);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            side_len     = '0;
            fade_len     = POS_W'(1);
            phase_inc    = '0;
            seg          = REG_SIDE_A;
            seg_pos      = '0;
            phase        = '0;
            stored_count = 0;
            errors       = 0;
            due_beats.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SIDE_LENGTH: side_len  = i_cfg_data[POS_W-1:0];
                    CFG_FADE_LENGTH: fade_len  = i_cfg_data[POS_W-1:0];
                    CFG_PHASE_STEP:  phase_inc = i_cfg_data[PHASE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                compress_sample(i_in_ch.in_sample);
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                check_beat(i_out_ch.out_sample, i_out_ch.block_done);
            end
        end
        o_errors    <= errors;
        o_pending   <= due_beats.size();
        // growing the fade during fade-in must not reach unwritten store entries
        o_fade_room <= (seg == REG_FADE_IN) ? stored_count : (1 << POS_W) - 1;
    end

endmodule

// File: sim/overlap_crossfade_time_compressor_test.sv
`timescale 1ns / 1ps

module overlap_crossfade_time_compressor_test import ocftc_pkg::*; ();

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int CALM_TAIL      = 250;
    localparam int PHASE_CAP      = 300;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    logic                 src_idle;
    logic                 snk_idle;
    int unsigned          stall_left;
    int unsigned          quiet_cycles;
    int                   fail_count;
    int                   beats_due;
    int                   fade_room;
    int                   random_sent;
    logic [POS_W-1:0]     side_now;
    logic [POS_W-1:0]     fade_now;

    ocftc_in_if  in_ch ();
    ocftc_out_if out_ch ();

    overlap_crossfade_time_compressor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    ocftc_compare u_compare (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_ch     (in_ch),
        .i_out_ch    (out_ch),
        .o_errors    (fail_count),
        .o_pending   (beats_due),
        .o_fade_room (fade_room)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (snk_idle && $urandom_range(0, 4) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 8);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
            (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("overlap_crossfade_time_compressor_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 11))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] far_length();
        case ($urandom_range(0, 2))
            0: return POS_W'(2048);
            1: return POS_W'(4095);
            default: return POS_W'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic apply_config(input bit do_side, input bit do_fade, input bit do_step,
                                input logic [POS_W-1:0] side, input logic [POS_W-1:0] fade,
                                input logic [PHASE_W-1:0] inc);
        if (do_side) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_SIDE_LENGTH;
            cfg_data <= CFG_W'(side);
            side_now = side;
            @(posedge i_clk);
        end
        if (do_fade) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_FADE_LENGTH;
            cfg_data <= CFG_W'(fade);
            fade_now = fade;
            @(posedge i_clk);
        end
        if (do_step) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_PHASE_STEP;
            cfg_data <= CFG_W'(inc);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] v);
        if (src_idle && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_sample <= v;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // fade-out beats give no output, so allow the pipe to empty after the last result
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (beats_due != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase();
        int                 pick;
        int                 n;
        int                 fade_e;
        bit                 tail;
        bit                 w_side;
        bit                 w_fade;
        bit                 w_step;
        logic [POS_W-1:0]   side;
        logic [POS_W-1:0]   fade;
        logic [PHASE_W-1:0] inc;
        drain();
        w_side = $urandom_range(0, 3) != 0;
        w_fade = $urandom_range(0, 3) != 0;
        w_step = $urandom_range(0, 3) != 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            side = POS_W'($urandom_range(0, 6));
        end else if (pick < 80) begin
            side = POS_W'($urandom_range(7, 40));
        end else if (pick < 88) begin
            side = '0;
        end else if (pick < 96) begin
            side = POS_W'($urandom_range(41, 400));
        end else begin
            side = far_length();
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            fade = POS_W'($urandom_range(1, 8));
        end else if (pick < 75) begin
            fade = POS_W'($urandom_range(9, 64));
        end else if (pick < 85) begin
            fade = '0;
        end else if (pick < 95) begin
            fade = POS_W'($urandom_range(65, 300));
        end else begin
            fade = far_length();
        end
        if (fade != 0 && int'(fade) > fade_room) begin
            fade = POS_W'(fade_room);
        end
        if (!w_side) begin
            side = side_now;
        end
        if (!w_fade) begin
            fade = fade_now;
        end
        fade_e = (fade == 0) ? 1 : ((fade > 2048) ? 2048 : int'(fade));
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            inc = PHASE_W'(65536 / fade_e);
        end else if (pick < 70) begin
            inc = '0;
        end else if (pick < 80) begin
            inc = '1;
        end else begin
            inc = PHASE_W'($urandom);
        end
        apply_config(w_side, w_fade, w_step, side, fade, inc);
        tail     = random_sent >= RANDOM_ITEMS - CALM_TAIL;
        src_idle = !tail && ($urandom_range(0, 9) < 7);
        snk_idle <= !tail && ($urandom_range(0, 9) < 7);
        if ($urandom_range(0, 1) == 1) begin
            n = (2 * int'(side_now) + 2 * fade_e) * int'($urandom_range(1, 3));
            if (n > PHASE_CAP) begin
                n = PHASE_CAP;
            end
        end else begin
            n = int'($urandom_range(1, 40));
        end
        repeat (n) begin
            push_sample(rand_sample());
            random_sent++;
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_SIDE_LENGTH;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.in_sample <= '0;
        snk_idle        <= 1'b0;
        src_idle        = 1'b0;
        side_now        = '0;
        fade_now        = POS_W'(1);
        random_sent     = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full block at half-scale window, extremes through every region
        apply_config(1'b1, 1'b1, 1'b1, 12'd1, 12'd2, 16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'hFFFF);
        drain();

        // large windows on both fades so the sum wraps
        apply_config(1'b1, 1'b1, 1'b1, 12'd2, 12'd3, 16'd43690);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h0001);
        push_sample(16'h0000);
        drain();

        // no side regions, zero fade length
        apply_config(1'b1, 1'b1, 1'b1, 12'd0, 12'd0, 16'hFFFF);
        push_sample(16'hFFFF);
        push_sample(16'h0001);
        push_sample(16'h8000);
        drain();

        // oversized lengths written mid-block, fade saturates
        apply_config(1'b1, 1'b1, 1'b1, 12'd4095, 12'd4095, 16'd32);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h3039);

        while (random_sent < RANDOM_ITEMS) begin
            random_phase();
        end

        drain();
        if (fail_count == 0) begin
            $display("overlap_crossfade_time_compressor_test: PASS");
        end else begin
            $display("overlap_crossfade_time_compressor_test: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
design/ocftc_pkg.sv
design/ocftc_in_if.sv
design/ocftc_out_if.sv
design/overlap_crossfade_time_compressor.sv
sim/ocftc_compare.sv
sim/overlap_crossfade_time_compressor_test.sv
